### src/rgbpwm_pkg.sv
package rgbpwm_pkg;

	localparam int LINE_LENGTH_DEF = 13;

	localparam int CHAR_W     = 8;
	localparam int DUTY_W     = 8;
	localparam int IN_DATA_W  = 8;
	// echo_char, four level/commit bits, three duties, padded to whole bytes
	localparam int OUT_FIELDS_W = CHAR_W + 4 + 3 * DUTY_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic [CHAR_W-1:0] CHAR_CR      = 8'd13;
	localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'd48;
	localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'd57;
	localparam logic [CHAR_W-1:0] CHAR_R_UPPER = 8'd82;
	localparam logic [CHAR_W-1:0] CHAR_R_LOWER = 8'd114;
	localparam logic [CHAR_W-1:0] CHAR_G_UPPER = 8'd71;
	localparam logic [CHAR_W-1:0] CHAR_G_LOWER = 8'd103;
	localparam logic [CHAR_W-1:0] CHAR_B_UPPER = 8'd66;
	localparam logic [CHAR_W-1:0] CHAR_B_LOWER = 8'd98;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_CHAR = 1'b1;

	typedef enum logic [1:0] {
		SEL_NONE  = 2'd0,
		SEL_RED   = 2'd1,
		SEL_GREEN = 2'd2,
		SEL_BLUE  = 2'd3
	} sel_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty_blue_now;
		logic [DUTY_W-1:0] duty_green_now;
		logic [DUTY_W-1:0] duty_red_now;
		logic              committed;
		logic              led_blue;
		logic              led_green;
		logic              led_red;
		logic [CHAR_W-1:0] echo_char;
	} result_t;

	// value * 10 + digit, modulo 256
	function automatic logic [DUTY_W-1:0] fold_digit(input logic [DUTY_W-1:0] v,
		input logic [DUTY_W-1:0] d);
		return (v << 3) + (v << 1) + d;
	endfunction

endpackage

### src/rgb_pwm_with_serial_command_parser_core.sv
// Three-channel 8-bit PWM LED driver with a serial color command parser.
// Input stream s_axis: tuser = command (0 PWM tick, 1 received character),
// tdata = received byte (ignored on ticks). Every input item yields exactly
// one result item on m_axis: tuser = echo_valid, tdata carries the echoed
// byte, the three LED levels, the commit flag and the three live duties.
// Characters: R/G/B (either case) select a channel and zero its pending
// value, digits fold in as value*10+digit, CR commits pending to live duties;
// a line of LINE_LENGTH uncommitted characters reverts pending and selection.
// The result is registered in the output register, or in the skid entry while
// the output holds one. Throughput: one item per cycle unless the skid is full;
// all parsing and PWM logic is one combinational pass off the state registers.
// The output register is backed by a one-entry skid register, so s_axis_tready
// depends only on registered state; it drops once both hold an unread result.
// Reset clears the counter, levels, duties, pending values, selection, line
// count and the valid flags of both output entries.
module rgb_pwm_with_serial_command_parser_core #(
	parameter int LINE_LENGTH = rgbpwm_pkg::LINE_LENGTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [rgbpwm_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [7:0] char_in
	input  logic                              s_axis_tuser,  // [0] command
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [7:0] echo_char, [8] led_red, [9] led_green, [10] led_blue, [11] committed,
	// [19:12] duty_red_now, [27:20] duty_green_now, [35:28] duty_blue_now
	output logic [rgbpwm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic                              m_axis_tuser   // [0] echo_valid
);
	import rgbpwm_pkg::*;

	localparam int CNT_W = (LINE_LENGTH > 2) ? $clog2(LINE_LENGTH) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LINE_LENGTH - 1);

	logic [DUTY_W-1:0] tick_q;
	logic              lvl_r_q, lvl_g_q, lvl_b_q;
	logic [DUTY_W-1:0] duty_r_q, duty_g_q, duty_b_q;
	logic [DUTY_W-1:0] pend_r_q, pend_g_q, pend_b_q;
	sel_t              sel_q;
	logic [CNT_W-1:0]  cnt_q;

	logic [DUTY_W-1:0] tick_d;
	logic              lvl_r_d, lvl_g_d, lvl_b_d;
	logic [DUTY_W-1:0] duty_r_d, duty_g_d, duty_b_d;
	logic [DUTY_W-1:0] pend_r_d, pend_g_d, pend_b_d;
	sel_t              sel_d;
	logic [CNT_W-1:0]  cnt_d;
	logic              commit_d;

	result_t res_d, out_q, skid_q;
	logic    echo_d, out_echo_q, skid_echo_q;
	logic    out_valid_q, skid_valid_q;

	logic accept, out_take;
	logic [CHAR_W-1:0] c;
	logic [DUTY_W-1:0] digit;
	logic              is_digit;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_take = out_valid_q && m_axis_tready;
	assign c        = s_axis_tdata;
	assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
	assign digit    = c - CHAR_ZERO;

	always_comb begin
		tick_d   = tick_q;
		lvl_r_d  = lvl_r_q;
		lvl_g_d  = lvl_g_q;
		lvl_b_d  = lvl_b_q;
		duty_r_d = duty_r_q;
		duty_g_d = duty_g_q;
		duty_b_d = duty_b_q;
		pend_r_d = pend_r_q;
		pend_g_d = pend_g_q;
		pend_b_d = pend_b_q;
		sel_d    = sel_q;
		cnt_d    = cnt_q;
		commit_d = 1'b0;
		if (s_axis_tuser == CMD_TICK) begin
			tick_d = tick_q + 1'b1;
			if (tick_d == '0) begin
				lvl_r_d = 1'b1;
				lvl_g_d = 1'b1;
				lvl_b_d = 1'b1;
			end
			if (tick_d == duty_r_q) lvl_r_d = 1'b0;
			if (tick_d == duty_g_q) lvl_g_d = 1'b0;
			if (tick_d == duty_b_q) lvl_b_d = 1'b0;
		end else if (c == CHAR_CR) begin
			duty_r_d = pend_r_q;
			duty_g_d = pend_g_q;
			duty_b_d = pend_b_q;
			cnt_d    = '0;
			sel_d    = SEL_NONE;
			commit_d = 1'b1;
		end else if (cnt_q == CNT_LAST) begin
			// line overflow: drop the edits in progress
			cnt_d    = '0;
			pend_r_d = duty_r_q;
			pend_g_d = duty_g_q;
			pend_b_d = duty_b_q;
			sel_d    = SEL_NONE;
		end else begin
			cnt_d = cnt_q + 1'b1;
			if (c == CHAR_R_UPPER || c == CHAR_R_LOWER) begin
				sel_d    = SEL_RED;
				pend_r_d = '0;
			end else if (c == CHAR_G_UPPER || c == CHAR_G_LOWER) begin
				sel_d    = SEL_GREEN;
				pend_g_d = '0;
			end else if (c == CHAR_B_UPPER || c == CHAR_B_LOWER) begin
				sel_d    = SEL_BLUE;
				pend_b_d = '0;
			end else if (is_digit) begin
				unique case (sel_q)
					SEL_RED:   pend_r_d = fold_digit(pend_r_q, digit);
					SEL_GREEN: pend_g_d = fold_digit(pend_g_q, digit);
					SEL_BLUE:  pend_b_d = fold_digit(pend_b_q, digit);
					default:   ;
				endcase
			end
		end
	end

	always_comb begin
		echo_d               = s_axis_tuser;
		res_d.echo_char      = (s_axis_tuser == CMD_CHAR) ? c : '0;
		res_d.led_red        = lvl_r_d;
		res_d.led_green      = lvl_g_d;
		res_d.led_blue       = lvl_b_d;
		res_d.committed      = commit_d;
		res_d.duty_red_now   = duty_r_d;
		res_d.duty_green_now = duty_g_d;
		res_d.duty_blue_now  = duty_b_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q   <= '0;
			lvl_r_q  <= 1'b0;
			lvl_g_q  <= 1'b0;
			lvl_b_q  <= 1'b0;
			duty_r_q <= '0;
			duty_g_q <= '0;
			duty_b_q <= '0;
			pend_r_q <= '0;
			pend_g_q <= '0;
			pend_b_q <= '0;
			sel_q    <= SEL_NONE;
			cnt_q    <= '0;
		end else if (accept) begin
			tick_q   <= tick_d;
			lvl_r_q  <= lvl_r_d;
			lvl_g_q  <= lvl_g_d;
			lvl_b_q  <= lvl_b_d;
			duty_r_q <= duty_r_d;
			duty_g_q <= duty_g_d;
			duty_b_q <= duty_b_d;
			pend_r_q <= pend_r_d;
			pend_g_q <= pend_g_d;
			pend_b_q <= pend_b_d;
			sel_q    <= sel_d;
			cnt_q    <= cnt_d;
		end
	end

	// output register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || out_take) begin
				out_valid_q  <= skid_valid_q || accept;
				skid_valid_q <= 1'b0;
			end else if (accept) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_take) begin
			if (skid_valid_q) begin
				out_q      <= skid_q;
				out_echo_q <= skid_echo_q;
			end else if (accept) begin
				out_q      <= res_d;
				out_echo_q <= echo_d;
			end
		end else if (accept) begin
			skid_q      <= res_d;
			skid_echo_q <= echo_d;
		end
	end

	assign s_axis_tready = !skid_valid_q;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_DATA_W'(out_q);
	assign m_axis_tuser  = out_echo_q;

endmodule

### bench/tb_rgb_pwm_with_serial_command_parser_core.sv
`timescale 1ns / 1ps

module tb_rgb_pwm_with_serial_command_parser_core;
	import rgbpwm_pkg::*;

	localparam int LINE_LEN     = LINE_LENGTH_DEF;
	localparam int RANDOM_ITEMS = 1800;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 300;
	localparam int N_DIRECTED   = 30;

	typedef struct packed {
		logic    echo_valid;
		result_t res;
	} out_item_t;

	// one directed item; the typed result is used only where typed is set
	typedef struct packed {
		logic              cmd;
		logic [CHAR_W-1:0] ch;
		logic              typed;
		logic              ev;
		logic [CHAR_W-1:0] echo;
		logic [2:0]        leds_bgr;
		logic              com;
		logic [DUTY_W-1:0] dr;
		logic [DUTY_W-1:0] dg;
		logic [DUTY_W-1:0] db;
	} row_t;

	localparam row_t DIRECTED [N_DIRECTED] = '{
		'{CMD_TICK, 8'h00,          1'b1, 1'b0, 8'd0,  3'b000, 1'b0, 8'd0,   8'd0,   8'd0},
		'{CMD_CHAR, CHAR_CR,        1'b1, 1'b1, 8'd13, 3'b000, 1'b1, 8'd0,   8'd0,   8'd0},
		'{CMD_CHAR, CHAR_R_UPPER,   1'b0, 1'b0, 8'd0,  3'b000, 1'b0, 8'd0,   8'd0,   8'd0},
		'{CMD_CHAR, CHAR_ZERO + 8'd2, 1'b0, 1'b0, 8'd0, 3'b000, 1'b0, 8'd0,  8'd0,   8'd0},
		'{CMD_CHAR, CHAR_ZERO + 8'd5, 1'b0, 1'b0, 8'd0, 3'b000, 1'b0, 8'd0,  8'd0,   8'd0},
		'{CMD_CHAR, CHAR_ZERO + 8'd5, 1'b0, 1'b0, 8'd0, 3'b000, 1'b0, 8'd0,  8'd0,   8'd0},
		'{CMD_CHAR, CHAR_CR,        1'b1, 1'b1, 8'd13, 3'b000, 1'b1, 8'd255, 8'd0,   8'd0},
		'{CMD_CHAR, CHAR_G_LOWER,   1'b0, 1'b0, 8'd0,  3'b000, 1'b0, 8'd0,   8'd0,   8'd0},
		'{CMD_CHAR, CHAR_NINE,      1'b0, 1'b0, 8'd0,  3'b000, 1'b0, 8'd0,   8'd0,   8'd0},
		'{CMD_CHAR, CHAR_NINE,      1'b0, 1'b0, 8'd0,  3'b000, 1'b0, 8'd0,   8'd0,   8'd0},
		// 999 wraps to 231
		'{CMD_CHAR, CHAR_NINE,      1'b0, 1'b0, 8'd0,  3'b000, 1'b0, 8'd0,   8'd0,   8'd0},
		'{CMD_CHAR, CHAR_B_LOWER,   1'b0, 1'b0, 8'd0,  3'b000, 1'b0, 8'd0,   8'd0,   8'd0},
		'{CMD_CHAR, CHAR_ZERO + 8'd1, 1'b0, 1'b0, 8'd0, 3'b000, 1'b0, 8'd0,  8'd0,   8'd0},
		'{CMD_CHAR, CHAR_CR,        1'b1, 1'b1, 8'd13, 3'b000, 1'b1, 8'd255, 8'd231, 8'd1},
		// twelve uncommitted characters, then the thirteenth wraps the line
		'{CMD_CHAR, CHAR_G_UPPER,   1'b0, 1'b0, 8'd0,  3'b000, 1'b0, 8'd0,   8'd0,   8'd0},
		'{CMD_CHAR, CHAR_ZERO + 8'd7, 1'b0, 1'b0, 8'd0, 3'b000, 1'b0, 8'd0,  8'd0,   8'd0},
		'{CMD_CHAR, CHAR_B_UPPER,   1'b0, 1'b0, 8'd0,  3'b000, 1'b0, 8'd0,   8'd0,   8'd0},
		'{CMD_CHAR, CHAR_R_LOWER,   1'b0, 1'b0, 8'd0,  3'b000, 1'b0, 8'd0,   8'd0,   8'd0},
		'{CMD_CHAR, 8'h44,          1'b0, 1'b0, 8'd0,  3'b000, 1'b0, 8'd0,   8'd0,   8'd0},
		'{CMD_CHAR, 8'h00,          1'b0, 1'b0, 8'd0,  3'b000, 1'b0, 8'd0,   8'd0,   8'd0},
		'{CMD_CHAR, 8'hFF,          1'b0, 1'b0, 8'd0,  3'b000, 1'b0, 8'd0,   8'd0,   8'd0},
		'{CMD_CHAR, CHAR_ZERO,      1'b0, 1'b0, 8'd0,  3'b000, 1'b0, 8'd0,   8'd0,   8'd0},
		'{CMD_CHAR, CHAR_NINE,      1'b0, 1'b0, 8'd0,  3'b000, 1'b0, 8'd0,   8'd0,   8'd0},
		'{CMD_CHAR, CHAR_ZERO - 8'd1, 1'b0, 1'b0, 8'd0, 3'b000, 1'b0, 8'd0,  8'd0,   8'd0},
		'{CMD_CHAR, CHAR_NINE + 8'd1, 1'b0, 1'b0, 8'd0, 3'b000, 1'b0, 8'd0,  8'd0,   8'd0},
		'{CMD_CHAR, CHAR_ZERO + 8'd3, 1'b0, 1'b0, 8'd0, 3'b000, 1'b0, 8'd0,  8'd0,   8'd0},
		'{CMD_CHAR, 8'h58,          1'b1, 1'b1, 8'd88, 3'b000, 1'b0, 8'd255, 8'd231, 8'd1},
		// digit with nothing selected
		'{CMD_CHAR, CHAR_ZERO + 8'd5, 1'b0, 1'b0, 8'd0, 3'b000, 1'b0, 8'd0,  8'd0,   8'd0},
		'{CMD_CHAR, CHAR_CR,        1'b1, 1'b1, 8'd13, 3'b000, 1'b1, 8'd255, 8'd231, 8'd1},
		'{CMD_TICK, 8'hFF,          1'b1, 1'b0, 8'd0,  3'b000, 1'b0, 8'd255, 8'd231, 8'd1}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;

	rgb_pwm_with_serial_command_parser_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// PWM and parser state as the block should hold it
	logic [7:0]        pwm_count = '0;
	logic              lvl_r = 1'b0, lvl_g = 1'b0, lvl_b = 1'b0;
	logic [DUTY_W-1:0] live_r = '0, live_g = '0, live_b = '0;
	logic [DUTY_W-1:0] next_r = '0, next_g = '0, next_b = '0;
	sel_t              chan = SEL_NONE;
	int                line_count = 0;

	out_item_t outputs_due[$];
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	bit        hold_request = 1'b0;
	int        hold_left = 0;
	int        fail_count = 0;
	int        items_sent = 0;
	int        cycle_count = 0;
	int        n_ticks = 0, n_chars = 0, n_commits = 0, n_wraps = 0, n_checked = 0;

	task automatic advance_led_driver(input logic cmd, input logic [CHAR_W-1:0] ch,
		output out_item_t o);
		logic [3:0] digit;
		logic       commit;
		commit = 1'b0;
		if (cmd == CMD_TICK) begin
			n_ticks++;
			pwm_count = pwm_count + 8'd1;
			if (pwm_count == 8'd0) begin
				lvl_r = 1'b1;
				lvl_g = 1'b1;
				lvl_b = 1'b1;
			end
			if (pwm_count == live_r) lvl_r = 1'b0;
			if (pwm_count == live_g) lvl_g = 1'b0;
			if (pwm_count == live_b) lvl_b = 1'b0;
		end else begin
			n_chars++;
			if (ch == CHAR_CR) begin
				live_r = next_r;
				live_g = next_g;
				live_b = next_b;
				line_count = 0;
				chan = SEL_NONE;
				commit = 1'b1;
				n_commits++;
			end else if (line_count + 1 >= LINE_LEN) begin
				// line full: this character is dropped, pending falls back to live
				line_count = 0;
				next_r = live_r;
				next_g = live_g;
				next_b = live_b;
				chan = SEL_NONE;
				n_wraps++;
			end else begin
				line_count++;
				if (ch == CHAR_R_UPPER || ch == CHAR_R_LOWER) begin
					chan = SEL_RED;
					next_r = '0;
				end else if (ch == CHAR_G_UPPER || ch == CHAR_G_LOWER) begin
					chan = SEL_GREEN;
					next_g = '0;
				end else if (ch == CHAR_B_UPPER || ch == CHAR_B_LOWER) begin
					chan = SEL_BLUE;
					next_b = '0;
				end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
					digit = 4'(ch - CHAR_ZERO);
					case (chan)
						SEL_RED:   next_r = 8'(next_r * 10 + digit);
						SEL_GREEN: next_g = 8'(next_g * 10 + digit);
						SEL_BLUE:  next_b = 8'(next_b * 10 + digit);
						default: ;
					endcase
				end
			end
		end
		o.echo_valid         = cmd;
		o.res.echo_char      = (cmd == CMD_CHAR) ? ch : '0;
		o.res.led_red        = lvl_r;
		o.res.led_green      = lvl_g;
		o.res.led_blue       = lvl_b;
		o.res.committed      = commit;
		o.res.duty_red_now   = live_r;
		o.res.duty_green_now = live_g;
		o.res.duty_blue_now  = live_b;
	endtask

	task automatic send_item(input logic cmd, input logic [CHAR_W-1:0] ch,
		input bit use_typed = 1'b0, input out_item_t typed = '0);
		out_item_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= ch;
		s_axis_tuser  <= cmd;
		do @(posedge clk); while (!s_axis_tready);
		advance_led_driver(cmd, ch, predicted);
		outputs_due.push_back(use_typed ? typed : predicted);
		items_sent++;
	endtask

	function automatic logic [CHAR_W-1:0] pick_letter();
		case ($urandom_range(5))
			0: return CHAR_R_UPPER;
			1: return CHAR_R_LOWER;
			2: return CHAR_G_UPPER;
			3: return CHAR_G_LOWER;
			4: return CHAR_B_UPPER;
			default: return CHAR_B_LOWER;
		endcase
	endfunction

	task automatic random_burst();
		int kind;
		kind = $urandom_range(99);
		if (kind < 40) begin
			// mostly short tick runs, now and then long enough to sweep the counter
			repeat (($urandom_range(19) == 0) ? $urandom_range(300, 60) : $urandom_range(20, 1))
				send_item(CMD_TICK, 8'($urandom));
		end else if (kind < 82) begin
			// well-formed command line: up to three channels, CR at the end
			repeat ($urandom_range(3, 1)) begin
				send_item(CMD_CHAR, pick_letter());
				repeat ($urandom_range(3)) begin
					send_item(CMD_CHAR, CHAR_ZERO + 8'($urandom_range(9)));
					if ($urandom_range(4) == 0)
						send_item(CMD_TICK, 8'($urandom));
				end
			end
			send_item(CMD_CHAR, CHAR_CR);
		end else if (kind < 94) begin
			repeat ($urandom_range(5, 1))
				send_item(CMD_CHAR, 8'($urandom));
		end else begin
			// no CR: runs past the line length
			repeat ($urandom_range(16, LINE_LEN))
				send_item(CMD_CHAR, $urandom_range(1) ? pick_letter()
					: CHAR_ZERO + 8'($urandom_range(9)));
		end
	endtask

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : watch_results
		out_item_t want;
		result_t   got;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[OUT_FIELDS_W-1:0];
				if (outputs_due.size() == 0) begin
					$error("result with nothing expected: tuser %0d tdata %h",
						m_axis_tuser, m_axis_tdata);
					fail_count++;
				end else begin
					want = outputs_due.pop_front();
					n_checked++;
					compare_field("echo_valid", want.echo_valid, m_axis_tuser);
					compare_field("echo_char", want.res.echo_char, got.echo_char);
					compare_field("led_red", want.res.led_red, got.led_red);
					compare_field("led_green", want.res.led_green, got.led_green);
					compare_field("led_blue", want.res.led_blue, got.led_blue);
					compare_field("committed", want.res.committed, got.committed);
					compare_field("duty_red_now", want.res.duty_red_now, got.duty_red_now);
					compare_field("duty_green_now", want.res.duty_green_now,
						got.duty_green_now);
					compare_field("duty_blue_now", want.res.duty_blue_now, got.duty_blue_now);
					compare_field("tdata padding", 0, int'(m_axis_tdata >> OUT_FIELDS_W));
				end
			end
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, outputs_due.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int        target;
		row_t      row;
		out_item_t typed;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = CMD_TICK;
		m_axis_tready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			row = DIRECTED[i];
			typed.echo_valid         = row.ev;
			typed.res.echo_char      = row.echo;
			typed.res.led_red        = row.leds_bgr[0];
			typed.res.led_green      = row.leds_bgr[1];
			typed.res.led_blue       = row.leds_bgr[2];
			typed.res.committed      = row.com;
			typed.res.duty_red_now   = row.dr;
			typed.res.duty_green_now = row.dg;
			typed.res.duty_blue_now  = row.db;
			send_item(row.cmd, row.ch, row.typed, typed);
		end

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
					// long sink stall while items keep coming: fills the output stage
					hold_request = 1'b1;
				end
				1: begin
					send_idle_pct = 66;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 66;
				end
				default: begin
					send_idle_pct = 31;
					recv_stall_pct = 31;
				end
			endcase
			target = items_sent + RANDOM_ITEMS / 4;
			while (items_sent < target)
				random_burst();
		end
		s_axis_tvalid <= 1'b0;

		while (outputs_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d items: %0d PWM ticks, %0d characters (%0d commits, %0d line wraps).",
			items_sent, n_ticks, n_chars, n_commits, n_wraps);
		$display("Checked %0d results under four idle/stall mixes and one long sink stall.",
			n_checked);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
